// ===== design/psd_pkg.sv =====
`default_nettype none

package psd_pkg;

    localparam int CoordW      = 32;
    localparam int RadiusW     = 31;
    localparam int ShapeW      = 2;
    localparam int CfgIdxW     = 3;
    localparam int FracBitsDef = 16;

    // center minus point, and its magnitude
    localparam int DiffW = CoordW + 1;
    localparam int AbsW  = CoordW;
    localparam int SqW   = 2 * AbsW;
    localparam int SumW  = SqW + 2;
    // radial length in the xy plane
    localparam int WxW   = SumW / 2;

    // cone and torus setup
    localparam int ArgW  = 42;
    localparam int MagW  = 37;
    localparam int LoW   = 18;
    localparam int HiW   = MagW - LoW;
    localparam int PartW = 2 * MagW;
    localparam int XW    = 76;
    localparam int RootW = 34;
    localparam int DistW = RootW + 2;

    // slope pair (9/8, -1): squared length of (9, -8) is 145
    localparam logic [7:0] SlopeDen = 8'd145;
    // floor of a sum of squares over 64
    localparam int RimShift = 6;

    typedef enum logic [ShapeW-1:0] {
        SHAPE_SPHERE = 2'd0,
        SHAPE_TORUS  = 2'd1,
        SHAPE_CONE   = 2'd2
    } t_shape;

    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } t_sgn;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SHAPE  = 3'd0,
        REG_CX     = 3'd1,
        REG_CY     = 3'd2,
        REG_CZ     = 3'd3,
        REG_MAJOR  = 3'd4,
        REG_MINOR  = 3'd5,
        REG_HEIGHT = 3'd6
    } t_reg;

    typedef struct packed {
        logic [ShapeW-1:0]        shape;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] cz;
        logic [RadiusW-1:0]       major;
        logic [RadiusW-1:0]       minor;
        logic [RadiusW-1:0]       height;
    } t_cfg;

    typedef struct packed {
        logic signed [DiffW-1:0] dz;
        logic [SumW-1:0]         all3;
    } t_side;

    typedef struct packed {
        logic [XW-1:0] xa;
        logic [XW-1:0] xb;
        logic          k145;
        logic          use_b;
    } t_dual;

endpackage

`default_nettype wire

// ===== design/psd_front.sv =====
`default_nettype none

module psd_front
    import psd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [CoordW-1:0] i_point_x,
    input  wire logic signed [CoordW-1:0] i_point_y,
    input  wire logic signed [CoordW-1:0] i_point_z,
    input  wire t_cfg                     i_cfg,
    output logic                          o_valid,
    output logic [SumW-1:0]               o_rad2,
    output t_side                         o_side
);

    function automatic logic [AbsW-1:0] abs_of(input logic signed [DiffW-1:0] v);
        abs_of = v[DiffW-1] ? AbsW'(-v) : AbsW'(v);
    endfunction

    logic                    r1_v, r2_v, r3_v;
    logic signed [DiffW-1:0] r1_dx, r1_dy, r1_dz, r2_dz, r3_dz;
    logic [SqW-1:0]          r2_sqx, r2_sqy, r2_sqz;
    logic [SumW-1:0]         r3_rad, r3_all3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r1_dx   <= DiffW'(i_cfg.cx) - DiffW'(i_point_x);
            r1_dy   <= DiffW'(i_cfg.cy) - DiffW'(i_point_y);
            r1_dz   <= DiffW'(i_cfg.cz) - DiffW'(i_point_z);

            r2_v    <= r1_v;
            r2_sqx  <= abs_of(r1_dx) * abs_of(r1_dx);
            r2_sqy  <= abs_of(r1_dy) * abs_of(r1_dy);
            r2_sqz  <= abs_of(r1_dz) * abs_of(r1_dz);
            r2_dz   <= r1_dz;

            r3_v    <= r2_v;
            r3_rad  <= SumW'(r2_sqx) + SumW'(r2_sqy);
            r3_all3 <= SumW'(r2_sqx) + SumW'(r2_sqy) + SumW'(r2_sqz);
            r3_dz   <= r2_dz;
        end
    end

    assign o_valid     = r3_v;
    assign o_rad2      = r3_rad;
    assign o_side.dz   = r3_dz;
    assign o_side.all3 = r3_all3;

endmodule

`default_nettype wire

// ===== design/psd_isqrt.sv =====
`default_nettype none

module psd_isqrt
    import psd_pkg::*;
#(
    parameter int NW = SumW,
    parameter int QW = WxW,
    parameter int PW = $bits(t_side)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_rad,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic [QW-1:0]      o_root,
    output logic [PW-1:0]      o_pay
);

    // one root bit per stage, most significant first
    logic [NW-1:0] r_rem  [1:QW];
    logic [QW-1:0] r_root [1:QW];
    logic [PW-1:0] r_pay  [1:QW];
    logic          r_vld  [1:QW];

    logic [NW-1:0] s_rem  [0:QW-1];
    logic [QW-1:0] s_root [0:QW-1];
    logic [PW-1:0] s_pay  [0:QW-1];
    logic          s_vld  [0:QW-1];

    logic [NW-1:0] n_rem   [1:QW];
    logic [QW-1:0] n_root  [1:QW];
    logic [NW-1:0] n_trial [1:QW];

    always_comb begin
        s_rem[0]  = i_rad;
        s_root[0] = '0;
        s_pay[0]  = i_pay;
        s_vld[0]  = i_valid;
        for (int j = 1; j < QW; j++) begin
            s_rem[j]  = r_rem[j];
            s_root[j] = r_root[j];
            s_pay[j]  = r_pay[j];
            s_vld[j]  = r_vld[j];
        end
        for (int j = 1; j <= QW; j++) begin
            n_trial[j] = (NW'(s_root[j-1]) << (QW - j + 1)) | (NW'(1) << (2 * (QW - j)));
            if (s_rem[j-1] >= n_trial[j]) begin
                n_rem[j]  = s_rem[j-1] - n_trial[j];
                n_root[j] = s_root[j-1] | (QW'(1) << (QW - j));
            end else begin
                n_rem[j]  = s_rem[j-1];
                n_root[j] = s_root[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j <= QW; j++) r_vld[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 1; j <= QW; j++) begin
                r_vld[j]  <= s_vld[j-1];
                r_pay[j]  <= s_pay[j-1];
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_root  = r_root[QW];
    assign o_pay   = r_pay[QW];

endmodule

`default_nettype wire

// ===== design/psd_prep.sv =====
`default_nettype none

module psd_prep
    import psd_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [WxW-1:0] i_wx,
    input  wire t_side          i_side,
    input  wire t_cfg           i_cfg,
    output logic                o_valid,
    output t_dual               o_req,
    output t_sgn                o_sgn
);

    typedef struct packed {
        logic k145;
        logic use_b;
        logic shift;
        logic sph;
        t_sgn sgn;
    } t_flags;

    function automatic logic [MagW-1:0] mag_of(input logic signed [ArgW-1:0] v);
        mag_of = v[ArgW-1] ? MagW'(-v) : MagW'(v);
    endfunction

    logic signed [ArgW-1:0] wxs, dzs, hs;

    // stage 1: cone and torus arguments
    logic                   r1_v;
    logic signed [ArgW-1:0] r1_e, r1_f, r1_s1, r1_s2, r1_g, r1_g8, r1_h145, r1_t;
    logic signed [ArgW-1:0] r1_dz, r1_wx;
    logic                   r1_hz;
    logic [SumW-1:0]        r1_all3;

    // stage 2: operand selection
    logic                   r2_v;
    logic [MagW-1:0]        r2_m [0:3];
    t_flags                 r2_f;
    logic [SumW-1:0]        r2_all3;
    logic [MagW-1:0]        n_m  [0:3];
    t_flags                 n_f;
    logic signed [ArgW-1:0] sgn_arg;

    // stage 3: partial products, stage 4: squares, stage 5: sums
    logic                   r3_v, r4_v, r5_v;
    logic [2*HiW-1:0]       r3_hh [0:3];
    logic [HiW+LoW-1:0]     r3_hl [0:3];
    logic [2*LoW-1:0]       r3_ll [0:3];
    t_flags                 r3_f, r4_f, r5_f;
    logic [SumW-1:0]        r3_all3, r4_all3;
    logic [PartW-1:0]       r4_sq [0:3];
    t_dual                  r5_req;
    logic [XW-1:0]          sum_a, sum_b;

    assign wxs = ArgW'(i_wx);
    assign dzs = ArgW'(i_side.dz);
    assign hs  = ArgW'(i_cfg.height);

    always_comb begin
        n_m[0] = '0;
        n_m[1] = '0;
        n_m[2] = '0;
        n_m[3] = '0;
        n_f    = '{k145: 1'b0, use_b: 1'b0, shift: 1'b0, sph: 1'b0, sgn: SGN_ZERO};
        sgn_arg = (r1_s1 > r1_s2) ? r1_s1 : r1_s2;
        case (i_cfg.shape)
            SHAPE_SPHERE: begin
                n_f.sph = 1'b1;
            end
            SHAPE_TORUS: begin
                n_m[0] = mag_of(r1_t);
                n_m[1] = mag_of(r1_dz);
            end
            SHAPE_CONE: begin
                // rim term always bounds the cone
                n_m[2]    = r1_e[ArgW-1] ? '0 : mag_of(r1_e);
                n_m[3]    = mag_of(r1_f);
                n_f.use_b = 1'b1;
                if (r1_g[ArgW-1] || r1_g == '0) begin
                    // apex is nearest
                    n_m[0] = mag_of(r1_wx);
                    n_m[1] = mag_of(r1_dz);
                end else if (r1_g8 >= r1_h145) begin
                    // rim corner is nearest
                    n_m[0]    = mag_of(r1_e);
                    n_m[1]    = mag_of(r1_f);
                    n_f.shift = 1'b1;
                end else begin
                    // projection onto the slanted side
                    n_m[0]   = mag_of(r1_s1);
                    n_f.k145 = 1'b1;
                end
                if (r1_hz || sgn_arg == '0) begin
                    n_f.sgn = SGN_ZERO;
                end else if (sgn_arg[ArgW-1]) begin
                    n_f.sgn = SGN_NEG;
                end else begin
                    n_f.sgn = SGN_POS;
                end
            end
            default: begin
                n_f.sph = 1'b0;
            end
        endcase
        sum_a = XW'(r4_sq[0]) + XW'(r4_sq[1]);
        sum_b = XW'(r4_sq[2]) + XW'(r4_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r1_e    <= (wxs <<< 3) - ((hs <<< 3) + hs);
            r1_f    <= (dzs + hs) <<< 3;
            r1_s1   <= (wxs <<< 3) + (dzs <<< 3) + dzs;
            r1_s2   <= -(dzs + hs);
            r1_g    <= (wxs <<< 3) + wxs - (dzs <<< 3);
            r1_g8   <= ((wxs <<< 3) + wxs - (dzs <<< 3)) <<< 3;
            r1_h145 <= (hs <<< 7) + (hs <<< 4) + hs;
            r1_t    <= wxs - ArgW'(i_cfg.major);
            r1_dz   <= dzs;
            r1_wx   <= wxs;
            r1_hz   <= (i_cfg.height == '0);
            r1_all3 <= i_side.all3;

            r2_v    <= r1_v;
            r2_f    <= n_f;
            r2_all3 <= r1_all3;
            for (int i = 0; i < 4; i++) r2_m[i] <= n_m[i];

            r3_v    <= r2_v;
            r3_f    <= r2_f;
            r3_all3 <= r2_all3;
            for (int i = 0; i < 4; i++) begin
                r3_hh[i] <= r2_m[i][MagW-1:LoW] * r2_m[i][MagW-1:LoW];
                r3_hl[i] <= r2_m[i][MagW-1:LoW] * r2_m[i][LoW-1:0];
                r3_ll[i] <= r2_m[i][LoW-1:0] * r2_m[i][LoW-1:0];
            end

            r4_v    <= r3_v;
            r4_f    <= r3_f;
            r4_all3 <= r3_all3;
            for (int i = 0; i < 4; i++) begin
                r4_sq[i] <= (PartW'(r3_hh[i]) << (2 * LoW))
                          + (PartW'(r3_hl[i]) << (LoW + 1))
                          + PartW'(r3_ll[i]);
            end

            r5_v <= r4_v;
            r5_f <= r4_f;
            if (r4_f.sph) begin
                r5_req.xa <= XW'(r4_all3);
            end else if (r4_f.shift) begin
                r5_req.xa <= sum_a >> RimShift;
            end else begin
                r5_req.xa <= sum_a;
            end
            r5_req.xb    <= r4_f.use_b ? (sum_b >> RimShift) : '0;
            r5_req.k145  <= r4_f.k145;
            r5_req.use_b <= r4_f.use_b;
        end
    end

    assign o_valid = r5_v;
    assign o_req   = r5_req;
    assign o_sgn   = r5_f.sgn;

endmodule

`default_nettype wire

// ===== design/psd_dual_sqrt.sv =====
`default_nettype none

module psd_dual_sqrt
    import psd_pkg::*;
#(
    parameter int QW = RootW
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_dual    i_req,
    input  wire t_sgn     i_sgn,
    output logic          o_valid,
    output logic [QW-1:0] o_root,
    output t_sgn          o_sgn
);

    // largest r with k*r^2 <= xa and, when enabled, r^2 <= xb
    localparam int RkW = QW + 8;

    logic [XW-1:0]  r_ra   [1:QW];
    logic [XW-1:0]  r_rb   [1:QW];
    logic [QW-1:0]  r_root [1:QW];
    logic [RkW-1:0] r_rk   [1:QW];
    logic           r_k145 [1:QW];
    logic           r_useb [1:QW];
    t_sgn           r_sgn  [1:QW];
    logic           r_vld  [1:QW];

    logic [XW-1:0]  s_ra   [0:QW-1];
    logic [XW-1:0]  s_rb   [0:QW-1];
    logic [QW-1:0]  s_root [0:QW-1];
    logic [RkW-1:0] s_rk   [0:QW-1];
    logic           s_k145 [0:QW-1];
    logic           s_useb [0:QW-1];
    t_sgn           s_sgn  [0:QW-1];
    logic           s_vld  [0:QW-1];

    logic [7:0]     n_k    [1:QW];
    logic [XW-1:0]  n_ta   [1:QW];
    logic [XW-1:0]  n_tb   [1:QW];
    logic           n_ok   [1:QW];

    always_comb begin
        s_ra[0]   = i_req.xa;
        s_rb[0]   = i_req.xb;
        s_root[0] = '0;
        s_rk[0]   = '0;
        s_k145[0] = i_req.k145;
        s_useb[0] = i_req.use_b;
        s_sgn[0]  = i_sgn;
        s_vld[0]  = i_valid;
        for (int j = 1; j < QW; j++) begin
            s_ra[j]   = r_ra[j];
            s_rb[j]   = r_rb[j];
            s_root[j] = r_root[j];
            s_rk[j]   = r_rk[j];
            s_k145[j] = r_k145[j];
            s_useb[j] = r_useb[j];
            s_sgn[j]  = r_sgn[j];
            s_vld[j]  = r_vld[j];
        end
        for (int j = 1; j <= QW; j++) begin
            n_k[j]  = s_k145[j-1] ? SlopeDen : 8'd1;
            n_ta[j] = (XW'(s_rk[j-1]) << (QW - j + 1)) + (XW'(n_k[j]) << (2 * (QW - j)));
            n_tb[j] = (XW'(s_root[j-1]) << (QW - j + 1)) | (XW'(1) << (2 * (QW - j)));
            n_ok[j] = (s_ra[j-1] >= n_ta[j]) && (!s_useb[j-1] || s_rb[j-1] >= n_tb[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j <= QW; j++) r_vld[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 1; j <= QW; j++) begin
                r_vld[j]  <= s_vld[j-1];
                r_k145[j] <= s_k145[j-1];
                r_useb[j] <= s_useb[j-1];
                r_sgn[j]  <= s_sgn[j-1];
                if (n_ok[j]) begin
                    r_ra[j]   <= s_ra[j-1] - n_ta[j];
                    r_rb[j]   <= s_rb[j-1] - n_tb[j];
                    r_root[j] <= s_root[j-1] | (QW'(1) << (QW - j));
                    r_rk[j]   <= s_rk[j-1] + (RkW'(n_k[j]) << (QW - j));
                end else begin
                    r_ra[j]   <= s_ra[j-1];
                    r_rb[j]   <= s_rb[j-1];
                    r_root[j] <= s_root[j-1];
                    r_rk[j]   <= s_rk[j-1];
                end
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_root  = r_root[QW];
    assign o_sgn   = r_sgn[QW];

endmodule

`default_nettype wire

// ===== design/primitive_signed_distance.sv =====
`default_nettype none
// Signed distance from a 3-D point to one sphere, torus or cone.
//
// Input channel: i_valid / o_stall carry one request, a query point
// (i_point_x/y/z, signed fixed point). Output channel: o_valid / i_stall
// carry one distance per request, in request order, saturated to 32 bits.
// Configuration goes through i_cfg_we / i_cfg_index / i_cfg_data and must
// only change while no request is in flight.
//
// From acceptance to o_valid a request passes the difference and squares,
// the radial root (one bit per stage), the torus and cone setup, the final
// root (one bit per stage) and the output register. Throughput is one
// request per cycle while the skid is empty: every stage is registered
// and the pipeline advances on a common enable.
//
// A skid register behind the output register absorbs the item that leaves
// the pipeline in the cycle the receiver stalls; o_stall is the skid's fill
// flag; the pipeline halts while the skid holds a result. Reset empties the
// pipeline and restores the default primitive (unit sphere at the origin).
module primitive_signed_distance
    import psd_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDef
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [CoordW-1:0] i_point_x,
    input  wire logic signed [CoordW-1:0] i_point_y,
    input  wire logic signed [CoordW-1:0] i_point_z,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [CoordW-1:0]      o_distance,
    input  wire logic                     i_cfg_we,
    input  wire logic [CfgIdxW-1:0]       i_cfg_index,
    input  wire logic [CoordW-1:0]        i_cfg_data
);

    t_cfg                    r_cfg;
    logic                    en;

    logic                    front_valid;
    logic [SumW-1:0]         front_rad2;
    t_side                   front_side;

    logic                    rt_valid;
    logic [WxW-1:0]          rt_wx;
    t_side                   rt_side;

    logic                    prep_valid;
    t_dual                   prep_req;
    t_sgn                    prep_sgn;

    logic                    dual_valid;
    logic [RootW-1:0]        dual_root;
    t_sgn                    dual_sgn;

    logic signed [DistW-1:0] mag_s;
    logic signed [DistW-1:0] n_dist;
    logic [CoordW-1:0]       sat;

    logic                    r_out_valid;
    logic [CoordW-1:0]       r_out_dist;
    logic                    r_skid_valid;
    logic [CoordW-1:0]       r_skid_dist;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape  <= SHAPE_SPHERE;
            r_cfg.cx     <= '0;
            r_cfg.cy     <= '0;
            r_cfg.cz     <= '0;
            r_cfg.major  <= RadiusW'(1) << FRAC_BITS;
            r_cfg.minor  <= RadiusW'(1) << (FRAC_BITS - 2);
            r_cfg.height <= RadiusW'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_SHAPE:  r_cfg.shape  <= i_cfg_data[ShapeW-1:0];
                REG_CX:     r_cfg.cx     <= i_cfg_data;
                REG_CY:     r_cfg.cy     <= i_cfg_data;
                REG_CZ:     r_cfg.cz     <= i_cfg_data;
                REG_MAJOR:  r_cfg.major  <= i_cfg_data[RadiusW-1:0];
                REG_MINOR:  r_cfg.minor  <= i_cfg_data[RadiusW-1:0];
                REG_HEIGHT: r_cfg.height <= i_cfg_data[RadiusW-1:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the skid holds a result.
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    psd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_cfg     (r_cfg),
        .o_valid   (front_valid),
        .o_rad2    (front_rad2),
        .o_side    (front_side)
    );

    // Radial length in the xy plane; the sphere sum and dz ride along.
    psd_isqrt #(
        .NW (SumW),
        .QW (WxW),
        .PW ($bits(t_side))
    ) u_radial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_rad   (front_rad2),
        .i_pay   (front_side),
        .o_valid (rt_valid),
        .o_root  (rt_wx),
        .o_pay   (rt_side)
    );

    psd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_valid),
        .i_wx    (rt_wx),
        .i_side  (rt_side),
        .i_cfg   (r_cfg),
        .o_valid (prep_valid),
        .o_req   (prep_req),
        .o_sgn   (prep_sgn)
    );

    psd_dual_sqrt #(
        .QW (RootW)
    ) u_dual (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_req   (prep_req),
        .i_sgn   (prep_sgn),
        .o_valid (dual_valid),
        .o_root  (dual_root),
        .o_sgn   (dual_sgn)
    );

    // Apply the surface offset or the cone sign, then clamp to 32 bits.
    always_comb begin
        mag_s = $signed(DistW'(dual_root));
        case (r_cfg.shape)
            SHAPE_SPHERE: n_dist = mag_s - $signed(DistW'(r_cfg.major));
            SHAPE_TORUS:  n_dist = mag_s - $signed(DistW'(r_cfg.minor));
            SHAPE_CONE: begin
                case (dual_sgn)
                    SGN_POS: n_dist = mag_s;
                    SGN_NEG: n_dist = -mag_s;
                    default: n_dist = '0;
                endcase
            end
            default: n_dist = '0;
        endcase
        if (n_dist[DistW-1:CoordW-1] == '0 || n_dist[DistW-1:CoordW-1] == '1) begin
            sat = n_dist[CoordW-1:0];
        end else if (n_dist[DistW-1]) begin
            sat = {1'b1, {(CoordW - 1){1'b0}}};
        end else begin
            sat = {1'b0, {(CoordW - 1){1'b1}}};
        end
    end

    // Output register with skid: a result leaving the pipeline while the
    // output is stalled parks in the skid, which then holds the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_dist   <= r_skid_dist;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= dual_valid;
                    r_out_dist  <= sat;
                end
            end else if (!r_skid_valid && dual_valid) begin
                r_skid_valid <= 1'b1;
                r_skid_dist  <= sat;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_out_dist;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled while the output was free");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> !r_skid_valid)
        else $error("skid not drained when the output advanced");

endmodule

`default_nettype wire
